[src/assert_macros.svh]
// Assertion macros shared by the escape-time pixel RTL.
// No dependencies; the files that check themselves include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/cetp_pkg.sv]
// Package for the escape-time pixel engine: payload structs, codes, constants.
// No dependencies; used by cetp_mul, cetp_div and celtic_escape_time_pixel.
`default_nettype none

package cetp_pkg;

  // Image geometry
  localparam int WIDTH  = 800;
  localparam int HEIGHT = 600;

  // Half the image size in pixels with 8 fraction bits
  localparam logic signed [33:0] HALF_X_Q8 = 34'(WIDTH * 128);
  localparam logic signed [33:0] HALF_Y_Q8 = 34'(HEIGHT * 128);

  // Escape bound: |z|^2 > 4 in Q16.48
  localparam logic [63:0] ESC_LIMIT = 64'h0004_0000_0000_0000;

  // Register reset values
  localparam logic [31:0] RST_PIXEL_SCALE = 32'd67109;
  localparam logic [9:0]  RST_MAX_ITER    = 10'd100;

  // Gray level divider: quotient bits and dividend width
  localparam int DIV_QBITS = 8;
  localparam int DIV_NUM_W = 18;

  // Input item
  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } in_pixel_t;

  // Result item
  typedef struct packed {
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [9:0] iterations;
    logic [7:0] gray_level;
  } out_result_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PIXEL_SCALE = 3'd0,
    REG_OFFSET_X    = 3'd1,
    REG_OFFSET_Y    = 3'd2,
    REG_JULIA_MODE  = 3'd3,
    REG_JULIA_RE    = 3'd4,
    REG_JULIA_IM    = 3'd5,
    REG_FORMULA     = 3'd6,
    REG_MAX_ITER    = 3'd7
  } cfg_idx_t;

  // Squaring formula variants
  typedef enum logic [1:0] {
    FML_ABS_RE   = 2'd0,  // re' = |rr-ii|, im' = t
    FML_ABS_BOTH = 2'd1,  // re' = |rr-ii|, im' = |t|
    FML_NEG_IM   = 2'd2,  // re' = rr-ii,   im' = -t
    FML_ABS_RA   = 2'd3   // re' = |ra+ii|, im' = t
  } fml_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_W,
    ST_SQR_RE,
    ST_SQR_IM,
    ST_CHECK,
    ST_STEP,
    ST_DIV_WAIT
  } state_t;

  // Operands of the shared multiplier
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_op_t;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [9:0]           den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QBITS-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[src/celtic_escape_time_pixel.sv]
// Escape-time pixel engine: one pixel in flight, one shared multiplier; each formula step
// runs through ST_SQR_RE, ST_SQR_IM, ST_CHECK and ST_STEP, and the multiplier is used
// three times per step, once per mapping.
// A new start transfer is taken in the cycle the result is strobed; the receiver cannot stall.
// Synchronous active-low reset: idle, no result pending, registers at their reset values.
`default_nettype none
`include "assert_macros.svh"

module celtic_escape_time_pixel (
  input  logic                   clk,
  input  logic                   rst_n,
  // pixel command
  input  logic                   start,
  output logic                   busy,
  input  cetp_pkg::in_pixel_t    in_data,
  // result
  output logic                   out_valid,
  output cetp_pkg::out_result_t  out_data,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  // Map product to Q8.24 with truncation toward zero and saturation
  function automatic logic signed [31:0] map_sat(input logic [63:0] p, input logic neg);
    logic [55:0] q;
    q = p[63:8];
    if (neg) begin
      if (q > 56'h0000_0080_0000_00) return 32'sh8000_0000;
      return (~q[31:0]) + 32'd1;
    end
    if (q > 56'h0000_007F_FFFF_FF) return 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  // Saturate a wide step result to 32 bits
  function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
    if (v > 44'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -44'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Configuration registers
  logic [31:0]         scale_r;
  logic signed [31:0]  offx_r, offy_r;
  logic                jmode_r;
  logic signed [31:0]  jre_r, jim_r;
  cetp_pkg::fml_t      fsel_r;
  logic [9:0]          max_r;

  // Sequencer and datapath registers
  cetp_pkg::state_t      state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cetp_pkg::out_result_t out_data_r, out_data_nxt;
  logic [9:0]            px_r, px_nxt, py_r, py_nxt;
  logic [31:0]           magx_r, magx_nxt, magy_r, magy_nxt;
  logic                  negx_r, negx_nxt, negy_r, negy_nxt;
  logic signed [31:0]    re_r, re_nxt, im_r, im_nxt;
  logic signed [31:0]    cre_r, cre_nxt, cim_r, cim_nxt;
  logic signed [63:0]    prr_r, prr_nxt, pii_r, pii_nxt;
  logic [9:0]            cnt_r, cnt_nxt;
  logic [9:0]            res_r, res_nxt;

  // Shared units
  cetp_pkg::mul_op_t   mul_op;
  logic signed [63:0]  prod_w;
  cetp_pkg::div_req_t  div_req;
  cetp_pkg::div_rsp_t  div_rsp;

  // Coordinate offsets at the start transfer
  logic signed [33:0]  dx_w, dy_w;
  logic [31:0]         magx_w, magy_w;

  // Step arithmetic
  logic signed [63:0]  rr_sh, ii_sh, t_sh, ra_sh;
  logic signed [43:0]  rr_w, ii_w, t_w, ra_w, ra_sel_w;
  logic signed [43:0]  diff_w, abs_diff_w, abs_t_w, sum_ra_w, abs_ra_w;
  logic signed [43:0]  nr_w, ni_w;
  logic signed [31:0]  step_re_w, step_im_w;
  logic signed [31:0]  map_x_w, map_y_w;
  logic [63:0]         mag2_w;
  logic                esc_w;
  logic [9:0]          fin_iter_w;
  logic                fin_w;

  cetp_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod_w)
  );

  cetp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Pixel position minus image center, in pixels with 8 fraction bits
  assign dx_w   = $signed({16'b0, in_data.pixel_x, 8'b0}) + 34'(offx_r) - cetp_pkg::HALF_X_Q8;
  assign dy_w   = $signed({16'b0, in_data.pixel_y, 8'b0}) + 34'(offy_r) - cetp_pkg::HALF_Y_Q8;
  assign magx_w = dx_w[33] ? 32'(-dx_w) : dx_w[31:0];
  assign magy_w = dy_w[33] ? 32'(-dy_w) : dy_w[31:0];

  assign map_x_w = map_sat(prod_w, negx_r);
  assign map_y_w = map_sat(prod_w, negy_r);

  // One formula step; prod_w holds re*im in ST_STEP
  always_comb begin
    rr_sh      = prr_r >>> 24;
    ii_sh      = pii_r >>> 24;
    t_sh       = prod_w >>> 23;
    ra_sh      = (-prr_r) >>> 24;
    rr_w       = rr_sh[43:0];
    ii_w       = ii_sh[43:0];
    t_w        = t_sh[43:0];
    ra_w       = ra_sh[43:0];
    ra_sel_w   = re_r[31] ? ra_w : rr_w;
    diff_w     = rr_w - ii_w;
    abs_diff_w = diff_w[43] ? -diff_w : diff_w;
    abs_t_w    = t_w[43] ? -t_w : t_w;
    sum_ra_w   = ra_sel_w + ii_w;
    abs_ra_w   = sum_ra_w[43] ? -sum_ra_w : sum_ra_w;
    case (fsel_r)
      cetp_pkg::FML_ABS_RE: begin
        nr_w = abs_diff_w;
        ni_w = t_w;
      end
      cetp_pkg::FML_ABS_BOTH: begin
        nr_w = abs_diff_w;
        ni_w = abs_t_w;
      end
      cetp_pkg::FML_NEG_IM: begin
        nr_w = diff_w;
        ni_w = -t_w;
      end
      default: begin
        nr_w = abs_ra_w;
        ni_w = t_w;
      end
    endcase
    step_re_w = sat44(nr_w + 44'(cre_r));
    step_im_w = sat44(ni_w + 44'(cim_r));
  end

  // Escape / limit test; prod_w holds im*im in ST_CHECK
  assign mag2_w     = $unsigned(prr_r) + $unsigned(prod_w);
  assign esc_w      = (cnt_r != 10'd0) && (mag2_w > cetp_pkg::ESC_LIMIT);
  assign fin_iter_w = esc_w ? (cnt_r - 10'd1) : cnt_r;
  assign fin_w      = esc_w || (cnt_r == max_r);

  // Sequencer: next state, multiplier operands, datapath updates
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    magx_nxt      = magx_r;
    magy_nxt      = magy_r;
    negx_nxt      = negx_r;
    negy_nxt      = negy_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    cre_nxt       = cre_r;
    cim_nxt       = cim_r;
    prr_nxt       = prr_r;
    pii_nxt       = pii_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    mul_op        = '0;
    div_req       = '0;
    case (state_r)
      cetp_pkg::ST_IDLE: begin
        if (start) begin
          px_nxt    = in_data.pixel_x;
          py_nxt    = in_data.pixel_y;
          magx_nxt  = magx_w;
          magy_nxt  = magy_w;
          negx_nxt  = dx_w[33];
          negy_nxt  = dy_w[33];
          state_nxt = cetp_pkg::ST_MAP_X;
        end
      end
      cetp_pkg::ST_MAP_X: begin
        mul_op.a  = {1'b0, magx_r};
        mul_op.b  = {1'b0, scale_r};
        state_nxt = cetp_pkg::ST_MAP_Y;
      end
      cetp_pkg::ST_MAP_Y: begin
        mul_op.a  = {1'b0, magy_r};
        mul_op.b  = {1'b0, scale_r};
        re_nxt    = map_x_w;
        state_nxt = cetp_pkg::ST_MAP_W;
      end
      cetp_pkg::ST_MAP_W: begin
        im_nxt    = map_y_w;
        cre_nxt   = jmode_r ? jre_r : re_r;
        cim_nxt   = jmode_r ? jim_r : map_y_w;
        cnt_nxt   = 10'd0;
        state_nxt = cetp_pkg::ST_SQR_RE;
      end
      cetp_pkg::ST_SQR_RE: begin
        mul_op.a  = 33'(re_r);
        mul_op.b  = 33'(re_r);
        state_nxt = cetp_pkg::ST_SQR_IM;
      end
      cetp_pkg::ST_SQR_IM: begin
        mul_op.a  = 33'(im_r);
        mul_op.b  = 33'(im_r);
        prr_nxt   = prod_w;
        state_nxt = cetp_pkg::ST_CHECK;
      end
      cetp_pkg::ST_CHECK: begin
        mul_op.a  = 33'(re_r);
        mul_op.b  = 33'(im_r);
        pii_nxt   = prod_w;
        if (fin_w) begin
          res_nxt       = fin_iter_w;
          div_req.start = 1'b1;
          div_req.num   = {fin_iter_w, 8'b0} - {8'b0, fin_iter_w};
          div_req.den   = max_r;
          state_nxt     = cetp_pkg::ST_DIV_WAIT;
        end else begin
          state_nxt = cetp_pkg::ST_STEP;
        end
      end
      cetp_pkg::ST_STEP: begin
        re_nxt    = step_re_w;
        im_nxt    = step_im_w;
        cnt_nxt   = cnt_r + 10'd1;
        state_nxt = cetp_pkg::ST_SQR_RE;
      end
      cetp_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          out_data_nxt.out_x      = px_r;
          out_data_nxt.out_y      = py_r;
          out_data_nxt.iterations = res_r;
          out_data_nxt.gray_level = (max_r == 10'd0) ? 8'd0 : div_rsp.quot;
          out_valid_nxt           = 1'b1;
          state_nxt               = cetp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cetp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cetp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    magx_r     <= magx_nxt;
    magy_r     <= magy_nxt;
    negx_r     <= negx_nxt;
    negy_r     <= negy_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    cre_r      <= cre_nxt;
    cim_r      <= cim_nxt;
    prr_r      <= prr_nxt;
    pii_r      <= pii_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
  end

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= cetp_pkg::RST_PIXEL_SCALE;
      offx_r  <= '0;
      offy_r  <= '0;
      jmode_r <= 1'b0;
      jre_r   <= '0;
      jim_r   <= '0;
      fsel_r  <= cetp_pkg::FML_ABS_RE;
      max_r   <= cetp_pkg::RST_MAX_ITER;
    end else if (cfg_valid) begin
      case (cetp_pkg::cfg_idx_t'(cfg_index))
        cetp_pkg::REG_PIXEL_SCALE: scale_r <= cfg_data;
        cetp_pkg::REG_OFFSET_X:    offx_r  <= cfg_data;
        cetp_pkg::REG_OFFSET_Y:    offy_r  <= cfg_data;
        cetp_pkg::REG_JULIA_MODE:  jmode_r <= cfg_data[0];
        cetp_pkg::REG_JULIA_RE:    jre_r   <= cfg_data;
        cetp_pkg::REG_JULIA_IM:    jim_r   <= cfg_data;
        cetp_pkg::REG_FORMULA:     fsel_r  <= cetp_pkg::fml_t'(cfg_data[1:0]);
        cetp_pkg::REG_MAX_ITER:    max_r   <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != cetp_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Result strobe lasts one cycle
  `ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r)
  // A start transfer makes the block busy
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  // Divider only finishes while the sequencer waits for it
  `ASSERT_IMPLIES(a_div_done_wait, clk, rst_n, div_rsp.done, state_r == cetp_pkg::ST_DIV_WAIT)

endmodule

`default_nettype wire

[src/cetp_mul.sv]
// Shared 33x33 signed multiplier with registered product.
// Depends on cetp_pkg (mul_op_t).
`default_nettype none

module cetp_mul (
  input  logic                   clk,
  input  cetp_pkg::mul_op_t      op,
  output logic signed [63:0]     prod
);

  logic signed [65:0] full_w;
  logic signed [63:0] prod_r;

  // Full product; all uses fit in 64 bits
  assign full_w = $signed(op.a) * $signed(op.b);

  always_ff @(posedge clk) begin
    prod_r <= $signed(full_w[63:0]);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

[src/cetp_div.sv]
// Restoring divider for the gray level, one quotient bit per cycle.
// Depends on cetp_pkg (div_req_t, div_rsp_t, DIV_QBITS, DIV_NUM_W).
`default_nettype none

module cetp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cetp_pkg::div_req_t req,
  output cetp_pkg::div_rsp_t rsp
);

  localparam int KW = $clog2(cetp_pkg::DIV_QBITS);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [KW-1:0]                  k_r, k_nxt;
  logic [cetp_pkg::DIV_NUM_W-1:0] rem_r, rem_nxt;
  logic [9:0]                     den_r, den_nxt;
  logic [cetp_pkg::DIV_QBITS-1:0] q_r, q_nxt;
  logic [cetp_pkg::DIV_NUM_W-1:0] shifted_w;
  logic                           ge_w;

  // Trial subtract of the divisor at the current quotient bit
  assign shifted_w = {{(cetp_pkg::DIV_NUM_W-10){1'b0}}, den_r} << k_r;
  assign ge_w      = (rem_r >= shifted_w);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      k_nxt    = KW'(cetp_pkg::DIV_QBITS - 1);
      rem_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      q_nxt = {q_r[cetp_pkg::DIV_QBITS-2:0], ge_w};
      if (ge_w) begin
        rem_nxt = rem_r - shifted_w;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for celtic_escape_time_pixel: directed and random pixels under many register
// settings, each result checked against an escape-time predictor kept in this file.
// Depends on cetp_pkg and the RTL of the escape-time pixel engine.

module tb;

  typedef longint unsigned u64_t;

  localparam real    CLK_PERIOD   = 12.0;
  localparam longint LIMIT_CYCLES = 6_000_000;
  localparam longint WORD_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WORD_MIN     = 64'shFFFF_FFFF_8000_0000;
  localparam int     PRINT_CAP    = 60;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  cetp_pkg::in_pixel_t   in_data   = '0;
  logic                  out_valid;
  cetp_pkg::out_result_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [31:0]           cfg_data  = '0;

  // Shadow copy of the configuration registers
  logic [31:0]        sh_scale;
  logic signed [31:0] sh_off_x;
  logic signed [31:0] sh_off_y;
  logic               sh_julia;
  logic signed [31:0] sh_jre;
  logic signed [31:0] sh_jim;
  cetp_pkg::fml_t     sh_fml;
  logic [9:0]         sh_max_iter;

  cetp_pkg::in_pixel_t   pixel_q[$];    // pixels waiting to be sent
  cetp_pkg::out_result_t escape_q[$];   // predicted results, oldest first
  int unsigned gap_left = 0;
  bit          no_gaps  = 1'b0;
  int          errors   = 0;

  celtic_escape_time_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Pixel to Q8.24 coordinate: magnitude product truncated, then saturated
  function automatic longint map_axis(logic [9:0] p, logic signed [31:0] off, longint half);
    longint d;
    u64_t   mag;
    u64_t   q;
    d   = longint'(p) * 256 + longint'(off) - half;
    mag = (d < 0) ? -d : d;
    q   = (mag * sh_scale) >> 8;
    if (d < 0) begin
      if (q > 64'd2147483648) return WORD_MIN;
      return -longint'(q);
    end
    if (q > 64'd2147483647) return WORD_MAX;
    return longint'(q);
  endfunction

  // Escape-time count and gray level for one pixel under the shadow registers
  function automatic cetp_pkg::out_result_t escape_result(cetp_pkg::in_pixel_t px);
    longint                re, im, cre, cim, rr, ii, t, nr, ni;
    u64_t                  mag2;
    int                    iter;
    int                    gray;
    cetp_pkg::out_result_t r;
    re  = map_axis(px.pixel_x, sh_off_x, cetp_pkg::WIDTH * 128);
    im  = map_axis(px.pixel_y, sh_off_y, cetp_pkg::HEIGHT * 128);
    cre = sh_julia ? longint'(sh_jre) : re;
    cim = sh_julia ? longint'(sh_jim) : im;
    for (iter = 0; iter < int'(sh_max_iter); iter++) begin
      rr = (re * re) >>> 24;
      ii = (im * im) >>> 24;
      t  = (re * im) >>> 23;
      case (sh_fml)
        cetp_pkg::FML_ABS_RE: begin
          nr = mag_of(rr - ii);
          ni = t;
        end
        cetp_pkg::FML_ABS_BOTH: begin
          nr = mag_of(rr - ii);
          ni = mag_of(t);
        end
        cetp_pkg::FML_NEG_IM: begin
          nr = rr - ii;
          ni = -t;
        end
        default: begin
          nr = mag_of(((re * mag_of(re)) >>> 24) + ii);
          ni = t;
        end
      endcase
      re   = sat_word(nr + cre);
      im   = sat_word(ni + cim);
      mag2 = re * re + im * im;
      if (mag2 > cetp_pkg::ESC_LIMIT) break;
    end
    gray         = (sh_max_iter == 0) ? 0 : (255 * iter) / int'(sh_max_iter);
    r.out_x      = px.pixel_x;
    r.out_y      = px.pixel_y;
    r.iterations = iter[9:0];
    r.gray_level = gray[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("%0t ns MISMATCH: %s", $realtime, msg);
  endtask

  // Idle length before the next pixel: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(16, 4);
    return $urandom_range(150, 40);
  endfunction

  // Pixel driver: start held until the transfer, predict at the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) escape_q = {escape_q, escape_result(in_data)};
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixel_q.size() != 0) begin
          start    <= 1'b1;
          in_data  <= pixel_q.pop_front();
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobe is one transfer, compared with the oldest prediction
  always @(posedge clk) begin
    cetp_pkg::out_result_t want;
    if (rst_n && out_valid) begin
      if (escape_q.size() == 0) begin
        report_mismatch($sformatf("result for (%0d,%0d) with nothing pending",
                                  out_data.out_x, out_data.out_y));
      end else begin
        want = escape_q.pop_front();
        if (out_data.out_x != want.out_x)
          report_mismatch($sformatf("out_x %0d, want %0d", out_data.out_x, want.out_x));
        if (out_data.out_y != want.out_y)
          report_mismatch($sformatf("out_y %0d, want %0d", out_data.out_y, want.out_y));
        if (out_data.iterations != want.iterations)
          report_mismatch($sformatf("iterations %0d, want %0d at (%0d,%0d)",
                                    out_data.iterations, want.iterations,
                                    want.out_x, want.out_y));
        if (out_data.gray_level != want.gray_level)
          report_mismatch($sformatf("gray_level %0d, want %0d at (%0d,%0d)",
                                    out_data.gray_level, want.gray_level,
                                    want.out_x, want.out_y));
      end
    end
  end

  // One register write transfer; the shadow follows it
  task automatic write_reg(cetp_pkg::cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cetp_pkg::REG_PIXEL_SCALE: sh_scale    = val;
      cetp_pkg::REG_OFFSET_X:    sh_off_x    = val;
      cetp_pkg::REG_OFFSET_Y:    sh_off_y    = val;
      cetp_pkg::REG_JULIA_MODE:  sh_julia    = val[0];
      cetp_pkg::REG_JULIA_RE:    sh_jre      = val;
      cetp_pkg::REG_JULIA_IM:    sh_jim      = val;
      cetp_pkg::REG_FORMULA:     sh_fml      = cetp_pkg::fml_t'(val[1:0]);
      default:                   sh_max_iter = val[9:0];
    endcase
  endtask

  task automatic set_all(logic [31:0] scale, logic [31:0] offx, logic [31:0] offy,
                         logic [31:0] jmode, logic [31:0] jre, logic [31:0] jim,
                         logic [31:0] fml, logic [31:0] maxit);
    write_reg(cetp_pkg::REG_PIXEL_SCALE, scale);
    write_reg(cetp_pkg::REG_OFFSET_X, offx);
    write_reg(cetp_pkg::REG_OFFSET_Y, offy);
    write_reg(cetp_pkg::REG_JULIA_MODE, jmode);
    write_reg(cetp_pkg::REG_JULIA_RE, jre);
    write_reg(cetp_pkg::REG_JULIA_IM, jim);
    write_reg(cetp_pkg::REG_FORMULA, fml);
    write_reg(cetp_pkg::REG_MAX_ITER, maxit);
  endtask

  task automatic push_pixel(int x, int y);
    cetp_pkg::in_pixel_t p;
    p.pixel_x = 10'(x);
    p.pixel_y = 10'(y);
    pixel_q   = {pixel_q, p};
  endtask

  // Block is idle once nothing is queued, driven or predicted
  task automatic wait_drained();
    do @(negedge clk); while (pixel_q.size() != 0 || start || escape_q.size() != 0);
  endtask

  function automatic logic [31:0] rand_offset();
    if ($urandom_range(99) < 80) return int'($urandom_range(204800)) - 102400;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_julia();
    if ($urandom_range(99) < 85) return int'($urandom_range(1 << 26)) - (1 << 25);
    return $urandom;
  endfunction

  initial begin
    cetp_pkg::fml_t      fml_list[4];
    int                  n_random;
    int                  n_items;
    int unsigned         r;
    logic [9:0]          mi;
    logic [31:0]         scale;
    logic [31:0]         maxit_word;
    cetp_pkg::in_pixel_t p;

    fml_list    = '{cetp_pkg::FML_ABS_RE, cetp_pkg::FML_ABS_BOTH, cetp_pkg::FML_NEG_IM,
                    cetp_pkg::FML_ABS_RA};
    n_random    = 0;
    sh_scale    = cetp_pkg::RST_PIXEL_SCALE;
    sh_off_x    = '0;
    sh_off_y    = '0;
    sh_julia    = 1'b0;
    sh_jre      = '0;
    sh_jim      = '0;
    sh_fml      = cetp_pkg::FML_ABS_RE;
    sh_max_iter = cetp_pkg::RST_MAX_ITER;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: image corners, center, and pixels outside the image
    @(negedge clk);
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(799, 599);
    push_pixel(400, 300);
    push_pixel(800, 600);
    push_pixel(0, 1023);
    push_pixel(1023, 0);
    push_pixel(200, 150);
    wait_drained();

    // Zero iteration limit
    set_all(cetp_pkg::RST_PIXEL_SCALE, 0, 0, 0, 0, 0, 32'(cetp_pkg::FML_ABS_RE), 0);
    push_pixel(400, 300);
    push_pixel(1023, 0);
    wait_drained();

    // Zero scale with extreme offsets: every pixel maps to the origin
    set_all(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 32'(cetp_pkg::FML_NEG_IM), 20);
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    wait_drained();

    // Full scale and extreme offsets: coordinate mapping saturates
    set_all(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0,
            32'(cetp_pkg::FML_ABS_BOTH), 5);
    push_pixel(1023, 1023);
    push_pixel(0, 0);
    wait_drained();

    // Extreme Julia constant: saturation in the step, escape on the first step
    set_all(cetp_pkg::RST_PIXEL_SCALE, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000,
            32'(cetp_pkg::FML_ABS_RA), 1023);
    push_pixel(400, 300);
    push_pixel(0, 0);
    wait_drained();

    // Each squaring variant; the first one runs the full 1023-step limit at the center
    foreach (fml_list[k]) begin
      set_all(cetp_pkg::RST_PIXEL_SCALE, 0, 0, k % 2, 32'hFF33_3333, 32'h0027_EF9D,
              32'(fml_list[k]), (fml_list[k] == cetp_pkg::FML_ABS_RE) ? 1023 : 30);
      push_pixel(400, 300);
      push_pixel(150, 420);
      wait_drained();
    end

    // Random phases: new settings each time, then a batch of random pixels
    while (n_random < 750) begin
      r = $urandom_range(99);
      if (r < 6) mi = 10'd1023;
      else if (r < 10) mi = 10'd0;
      else if (r < 25) mi = 10'($urandom_range(255, 65));
      else mi = 10'($urandom_range(64, 1));
      maxit_word       = $urandom;
      maxit_word[9:0]  = mi;

      r = $urandom_range(99);
      if (r < 8) scale = $urandom;
      else if (r < 12) scale = 1;
      else if (r < 15) scale = 0;
      else scale = $urandom_range(300000, 2000);

      set_all(scale, rand_offset(), rand_offset(), $urandom, rand_julia(), rand_julia(),
              $urandom, maxit_word);

      no_gaps = ($urandom_range(5) == 0);
      n_items = (mi > 255) ? 5 : 50;
      @(negedge clk);
      repeat (n_items) begin
        if ($urandom_range(99) < 85) begin
          p.pixel_x = 10'($urandom_range(cetp_pkg::WIDTH - 1));
          p.pixel_y = 10'($urandom_range(cetp_pkg::HEIGHT - 1));
        end else begin
          p.pixel_x = 10'($urandom_range(1023));
          p.pixel_y = 10'($urandom_range(1023));
        end
        pixel_q = {pixel_q, p};
      end
      n_random += n_items;
      wait_drained();
    end

    // Allow for a stray late result before the verdict
    repeat (4 * int'(sh_max_iter) + 40) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
